// File: hdl/ft8cs_pkg.sv
// ----------------------------------------------------------------------------
// ft8cs_pkg
// Types and constants shared by the FT8 contact sequencer files.
// ----------------------------------------------------------------------------
package ft8cs_pkg;

  localparam int unsigned STAMP_WIDTH = 32;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_MSG   = 2'd1,
    ACT_CQ    = 2'd2,
    ACT_CLICK = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    RX_CQ    = 3'd0,
    RX_LOC   = 3'd1,
    RX_RSL   = 3'd2,
    RX_RRSL  = 3'd3,
    RX_73    = 3'd4,
    RX_RR73  = 3'd5,
    RX_RRR   = 3'd6,
    RX_OTHER = 3'd7
  } rx_kind_t;

  typedef enum logic [2:0] {
    TX_CQ   = 3'd0,
    TX_LOC  = 3'd1,
    TX_RSL  = 3'd2,
    TX_RRSL = 3'd3,
    TX_RRR  = 3'd4,
    TX_73   = 3'd5
  } tx_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE         = 5'd0,
    ST_CQ_PENDING   = 5'd1,
    ST_XMIT_CQ      = 5'd2,
    ST_LISTEN_LOC   = 5'd3,
    ST_RSL_PENDING  = 5'd4,
    ST_XMIT_RSL     = 5'd5,
    ST_LISTEN_RRSL  = 5'd6,
    ST_RRR_PENDING  = 5'd7,
    ST_XMIT_RRR     = 5'd8,
    ST_LISTEN_73    = 5'd9,
    ST_LOC_PENDING  = 5'd10,
    ST_XMIT_LOC     = 5'd11,
    ST_LISTEN_RSL   = 5'd12,
    ST_RRSL_PENDING = 5'd13,
    ST_XMIT_RRSL    = 5'd14,
    ST_LISTEN_RRR   = 5'd15,
    ST_M73_PENDING  = 5'd16,
    ST_XMIT_73      = 5'd17
  } seq_state_t;

  // one event as taken from the input channel
  typedef struct packed {
    action_t    action;
    logic [2:0] msg_kind;
    logic       for_us;
    logic       text_has_rr73;
    logic       click_valid;
    logic       click_slot_odd;
  } evt_t;

  // per-event strobes from the sequencer step logic
  typedef struct packed {
    logic       arm_transmit;
    logic       prepare_valid;
    tx_kind_t   prepared_kind;
    logic       disarm_and_clear;
    logic       qso_start;
    logic       save_locator;
    logic       save_my_report;
    logic       load_remote_info;
  } step_flags_t;

endpackage

// File: hdl/ft8cs_if.sv
// ----------------------------------------------------------------------------
// ft8cs_in_if / ft8cs_out_if
// Valid/ready channels carrying sequencer events and sequencer results.
// ----------------------------------------------------------------------------
interface ft8cs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] msg_kind;
  logic       for_us;
  logic       text_has_rr73;
  logic       click_valid;
  logic       click_slot_odd;

  modport source (
    output valid, action, msg_kind, for_us, text_has_rr73, click_valid, click_slot_odd,
    input  ready
  );
  modport sink (
    input  valid, action, msg_kind, for_us, text_has_rr73, click_valid, click_slot_odd,
    output ready
  );
endinterface

interface ft8cs_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  state_now;
  logic        arm_transmit;
  logic        prepare_valid;
  logic [2:0]  prepared_kind;
  logic        disarm_and_clear;
  logic        qso_start;
  logic        qso_slot_odd;
  logic        save_locator;
  logic        save_my_report;
  logic        load_remote_info;
  logic [31:0] slot_stamp;

  modport source (
    output valid, state_now, arm_transmit, prepare_valid, prepared_kind,
           disarm_and_clear, qso_start, qso_slot_odd, save_locator,
           save_my_report, load_remote_info, slot_stamp,
    input  ready
  );
  modport sink (
    input  valid, state_now, arm_transmit, prepare_valid, prepared_kind,
           disarm_and_clear, qso_start, qso_slot_odd, save_locator,
           save_my_report, load_remote_info, slot_stamp,
    output ready
  );
endinterface

// File: hdl/ft8cs_step.sv
// ----------------------------------------------------------------------------
// ft8cs_step
// Next-state and strobe logic of the contact sequencer for one event.
// ----------------------------------------------------------------------------
module ft8cs_step (
  input  ft8cs_pkg::seq_state_t  state_i,
  input  logic                   parity_i,
  input  logic                   cnt_odd_i,
  input  ft8cs_pkg::evt_t        evt_i,
  output ft8cs_pkg::seq_state_t  state_o,
  output logic                   parity_o,
  output ft8cs_pkg::step_flags_t flags_o
);
  import ft8cs_pkg::*;

  logic [2:0] kind;
  logic       cq_side;
  logic       fin_listen;
  logic       arm_ok;

  always_comb begin
    // locator carrying rr73 in its text counts as rr73
    kind       = (evt_i.msg_kind == RX_LOC && evt_i.text_has_rr73) ? RX_RR73 : evt_i.msg_kind;
    cq_side    = (state_i == ST_CQ_PENDING) || (state_i == ST_XMIT_CQ) ||
                 (state_i == ST_LISTEN_LOC);
    fin_listen = (state_i == ST_LISTEN_73) || (state_i == ST_LISTEN_RRR);
    arm_ok     = (parity_i == cnt_odd_i);
  end

  always_comb begin
    state_o  = state_i;
    parity_o = parity_i;
    flags_o  = '0;
    unique case (evt_i.action)
      ACT_TICK: begin
        unique case (state_i)
          ST_CQ_PENDING, ST_LISTEN_LOC: begin
            flags_o.arm_transmit = 1'b1;
            state_o              = ST_XMIT_CQ;
          end
          ST_XMIT_CQ:     state_o = ST_LISTEN_LOC;
          ST_RSL_PENDING, ST_LISTEN_RRSL: begin
            if (arm_ok) begin
              flags_o.arm_transmit = 1'b1;
              state_o              = ST_XMIT_RSL;
            end
          end
          ST_XMIT_RSL:    state_o = ST_LISTEN_RRSL;
          ST_RRR_PENDING: begin
            if (arm_ok) begin
              flags_o.arm_transmit = 1'b1;
              state_o              = ST_XMIT_RRR;
            end
          end
          ST_XMIT_RRR:    state_o = ST_LISTEN_73;
          ST_LISTEN_73:   state_o = ST_IDLE;
          ST_LOC_PENDING: begin
            if (arm_ok) begin
              flags_o.arm_transmit = 1'b1;
              state_o              = ST_XMIT_LOC;
            end
          end
          ST_XMIT_LOC:    state_o = ST_LISTEN_RSL;
          ST_RRSL_PENDING: begin
            if (arm_ok) begin
              flags_o.arm_transmit = 1'b1;
              state_o              = ST_XMIT_RRSL;
            end
          end
          ST_XMIT_RRSL:   state_o = ST_LISTEN_RRR;
          ST_M73_PENDING: begin
            if (arm_ok) begin
              flags_o.arm_transmit = 1'b1;
              state_o              = ST_XMIT_73;
            end
          end
          ST_XMIT_73:     state_o = ST_IDLE;
          default: ;
        endcase
      end

      ACT_MSG: begin
        if (evt_i.for_us) begin
          unique case (kind)
            RX_LOC: begin
              if (state_i == ST_CQ_PENDING || state_i == ST_LISTEN_LOC) begin
                flags_o.qso_start        = 1'b1;
                flags_o.save_locator     = 1'b1;
                flags_o.load_remote_info = 1'b1;
                flags_o.prepare_valid    = 1'b1;
                flags_o.prepared_kind    = TX_RSL;
                parity_o                 = cnt_odd_i;
                state_o                  = ST_RSL_PENDING;
              end
            end
            RX_RSL, RX_RRSL: begin
              priority if (state_i == ST_LISTEN_RRSL) begin
                flags_o.save_my_report   = 1'b1;
                flags_o.load_remote_info = 1'b1;
                flags_o.prepare_valid    = 1'b1;
                flags_o.prepared_kind    = TX_RRR;
                state_o                  = ST_RRR_PENDING;
              end else if (state_i == ST_LISTEN_RSL) begin
                flags_o.save_my_report   = 1'b1;
                flags_o.load_remote_info = 1'b1;
                flags_o.prepare_valid    = 1'b1;
                flags_o.prepared_kind    = TX_RRSL;
                state_o                  = ST_RRSL_PENDING;
              end else if (state_i == ST_LISTEN_LOC) begin
                flags_o.qso_start        = 1'b1;
                flags_o.save_my_report   = 1'b1;
                flags_o.load_remote_info = 1'b1;
                flags_o.prepare_valid    = 1'b1;
                flags_o.prepared_kind    = TX_RSL;
                parity_o                 = cnt_odd_i;
                state_o                  = ST_RSL_PENDING;
              end
            end
            RX_73: begin
              priority if (fin_listen) begin
                state_o = ST_IDLE;
              end else if (!cq_side) begin
                flags_o.disarm_and_clear = 1'b1;
                state_o                  = ST_IDLE;
              end
            end
            RX_RR73, RX_RRR: begin
              priority if (fin_listen) begin
                flags_o.load_remote_info = 1'b1;
                flags_o.prepare_valid    = 1'b1;
                flags_o.prepared_kind    = TX_73;
                state_o                  = ST_M73_PENDING;
              end else if (!cq_side) begin
                flags_o.disarm_and_clear = 1'b1;
                state_o                  = ST_IDLE;
              end
            end
            default: ;
          endcase
        end
      end

      ACT_CQ: begin
        priority if (state_i == ST_IDLE || state_i == ST_LOC_PENDING) begin
          flags_o.prepare_valid = 1'b1;
          flags_o.prepared_kind = TX_CQ;
          state_o               = ST_CQ_PENDING;
        end else if (cq_side) begin
          flags_o.disarm_and_clear = 1'b1;
          state_o                  = ST_IDLE;
        end
      end

      ACT_CLICK: begin
        if (evt_i.click_valid && (state_i == ST_IDLE || state_i == ST_CQ_PENDING)) begin
          flags_o.qso_start        = 1'b1;
          flags_o.save_locator     = 1'b1;
          flags_o.load_remote_info = 1'b1;
          flags_o.prepare_valid    = 1'b1;
          flags_o.prepared_kind    = TX_LOC;
          parity_o                 = evt_i.click_slot_odd;
          state_o                  = ST_LOC_PENDING;
        end
      end

      default: ;
    endcase
  end

endmodule

// File: hdl/ft8cs_contact_sequencer_core.sv
// ----------------------------------------------------------------------------
// ft8_contact_sequencer_core
// FT8 contact sequencer: state, timeslot counter and remote slot parity.
// ----------------------------------------------------------------------------
// out_ch is driven from the result register, loaded from the event register
// throughput: one event per cycle unless out_ch stalls, set by the
//   single-pass step logic between the event register and the result register
// reset (rst_n low, synchronous): state idle, slot counter zero, parity zero,
//   both pipeline registers empty
module ft8_contact_sequencer_core #(
  parameter int unsigned SLOT_COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  ft8cs_in_if.sink     in_ch,
  ft8cs_out_if.source  out_ch
);
  import ft8cs_pkg::*;

  logic                        evt_v_r;
  evt_t                        evt_r;
  logic                        res_v_r;

  seq_state_t                  state_r;
  logic [SLOT_COUNT_WIDTH-1:0] cnt_r;
  logic                        parity_r;

  seq_state_t                  state_nxt;
  logic                        parity_nxt;
  step_flags_t                 flags;
  logic [SLOT_COUNT_WIDTH-1:0] cnt_nxt;
  logic [63:0]                 cnt_ext;

  step_flags_t                 flags_r;
  seq_state_t                  res_state_r;
  logic                        res_parity_r;
  logic [STAMP_WIDTH-1:0]      stamp_r;

  logic                        out_free;
  logic                        advance;
  logic                        take;

  assign out_free    = !res_v_r || out_ch.ready;
  assign advance     = evt_v_r && out_free;
  assign in_ch.ready = !evt_v_r || out_free;
  assign take        = in_ch.valid && in_ch.ready;

  ft8cs_step u_step (
    .state_i   (state_r),
    .parity_i  (parity_r),
    .cnt_odd_i (cnt_r[0]),
    .evt_i     (evt_r),
    .state_o   (state_nxt),
    .parity_o  (parity_nxt),
    .flags_o   (flags)
  );

  always_comb begin
    cnt_nxt = (evt_r.action == ACT_TICK) ? cnt_r + 1'b1 : cnt_r;
    cnt_ext = 64'(cnt_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_v_r  <= 1'b0;
      res_v_r  <= 1'b0;
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      parity_r <= 1'b0;
    end else begin
      if (take) begin
        evt_v_r <= 1'b1;
      end else if (advance) begin
        evt_v_r <= 1'b0;
      end
      if (advance) begin
        res_v_r  <= 1'b1;
        state_r  <= state_nxt;
        cnt_r    <= cnt_nxt;
        parity_r <= parity_nxt;
      end else if (out_ch.ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      evt_r.action         <= action_t'(in_ch.action);
      evt_r.msg_kind       <= in_ch.msg_kind;
      evt_r.for_us         <= in_ch.for_us;
      evt_r.text_has_rr73  <= in_ch.text_has_rr73;
      evt_r.click_valid    <= in_ch.click_valid;
      evt_r.click_slot_odd <= in_ch.click_slot_odd;
    end
    if (advance) begin
      flags_r      <= flags;
      res_state_r  <= state_nxt;
      res_parity_r <= parity_nxt;
      stamp_r      <= cnt_ext[STAMP_WIDTH-1:0];
    end
  end

  assign out_ch.valid            = res_v_r;
  assign out_ch.state_now        = res_state_r;
  assign out_ch.arm_transmit     = flags_r.arm_transmit;
  assign out_ch.prepare_valid    = flags_r.prepare_valid;
  assign out_ch.prepared_kind    = flags_r.prepared_kind;
  assign out_ch.disarm_and_clear = flags_r.disarm_and_clear;
  assign out_ch.qso_start        = flags_r.qso_start;
  assign out_ch.qso_slot_odd     = res_parity_r;
  assign out_ch.save_locator     = flags_r.save_locator;
  assign out_ch.save_my_report   = flags_r.save_my_report;
  assign out_ch.load_remote_info = flags_r.load_remote_info;
  assign out_ch.slot_stamp       = stamp_r;

endmodule

// File: verif/ft8_contact_sequencer_core_test.sv
// ----------------------------------------------------------------------------
// ft8_contact_sequencer_core_test
// Self-checking bench for the FT8 contact sequencer. Events go in over the
// valid/ready input channel and a scoreboard predicts each result from its
// own copy of the state, slot counter and remote parity. Directed contacts
// come first, then state-aware random traffic under three idling mixes, a
// long receiver hold-off and a drain between phases.
// ----------------------------------------------------------------------------
module ft8_contact_sequencer_core_test;
  import ft8cs_pkg::*;

  typedef struct packed {
    seq_state_t  state_now;
    logic        arm_transmit;
    logic        prepare_valid;
    tx_kind_t    prepared_kind;
    logic        disarm_and_clear;
    logic        qso_start;
    logic        qso_slot_odd;
    logic        save_locator;
    logic        save_my_report;
    logic        load_remote_info;
    logic [31:0] slot_stamp;
  } seq_result_t;

  class sequencer_scoreboard;
    seq_state_t  st;
    logic [31:0] slot_cnt;
    logic        remote_odd;
    seq_result_t due_results[$];
    int          errors;

    function new();
      st         = ST_IDLE;
      slot_cnt   = '0;
      remote_odd = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // calling CQ states are left alone by an early end
    function bit in_cq_phase(seq_state_t s);
      return (s == ST_CQ_PENDING) || (s == ST_XMIT_CQ) || (s == ST_LISTEN_LOC);
    endfunction

    function void arm_on_parity(inout seq_result_t r, input seq_state_t nxt);
      if (remote_odd == slot_cnt[0]) begin
        r.arm_transmit = 1'b1;
        st = nxt;
      end
    endfunction

    function void note_event(evt_t e);
      seq_result_t r;
      rx_kind_t    kind;
      seq_state_t  s;
      r = '0;
      r.slot_stamp = slot_cnt;
      s = st;
      case (e.action)
        ACT_TICK: begin
          case (s)
            ST_CQ_PENDING, ST_LISTEN_LOC: begin
              r.arm_transmit = 1'b1;
              st = ST_XMIT_CQ;
            end
            ST_XMIT_CQ:                     st = ST_LISTEN_LOC;
            ST_RSL_PENDING, ST_LISTEN_RRSL: arm_on_parity(r, ST_XMIT_RSL);
            ST_XMIT_RSL:                    st = ST_LISTEN_RRSL;
            ST_RRR_PENDING:                 arm_on_parity(r, ST_XMIT_RRR);
            ST_XMIT_RRR:                    st = ST_LISTEN_73;
            ST_LISTEN_73:                   st = ST_IDLE;
            ST_LOC_PENDING:                 arm_on_parity(r, ST_XMIT_LOC);
            ST_XMIT_LOC:                    st = ST_LISTEN_RSL;
            ST_RRSL_PENDING:                arm_on_parity(r, ST_XMIT_RRSL);
            ST_XMIT_RRSL:                   st = ST_LISTEN_RRR;
            ST_M73_PENDING:                 arm_on_parity(r, ST_XMIT_73);
            ST_XMIT_73:                     st = ST_IDLE;
            default: ;
          endcase
          slot_cnt = slot_cnt + 32'd1;
        end
        ACT_MSG: begin
          kind = rx_kind_t'(e.msg_kind);
          // a locator carrying rr73 in its text counts as an rr73
          if (kind == RX_LOC && e.text_has_rr73) kind = RX_RR73;
          if (e.for_us) begin
            case (kind)
              RX_LOC: begin
                if (s == ST_CQ_PENDING || s == ST_LISTEN_LOC) begin
                  r.qso_start = 1'b1;
                  remote_odd = slot_cnt[0];
                  r.save_locator = 1'b1;
                  r.load_remote_info = 1'b1;
                  r.prepare_valid = 1'b1;
                  r.prepared_kind = TX_RSL;
                  st = ST_RSL_PENDING;
                end
              end
              RX_RSL, RX_RRSL: begin
                if (s == ST_LISTEN_RRSL) begin
                  r.save_my_report = 1'b1;
                  r.load_remote_info = 1'b1;
                  r.prepare_valid = 1'b1;
                  r.prepared_kind = TX_RRR;
                  st = ST_RRR_PENDING;
                end else if (s == ST_LISTEN_RSL) begin
                  r.save_my_report = 1'b1;
                  r.load_remote_info = 1'b1;
                  r.prepare_valid = 1'b1;
                  r.prepared_kind = TX_RRSL;
                  st = ST_RRSL_PENDING;
                end else if (s == ST_LISTEN_LOC) begin
                  r.qso_start = 1'b1;
                  remote_odd = slot_cnt[0];
                  r.save_my_report = 1'b1;
                  r.load_remote_info = 1'b1;
                  r.prepare_valid = 1'b1;
                  r.prepared_kind = TX_RSL;
                  st = ST_RSL_PENDING;
                end
              end
              RX_73: begin
                if (s == ST_LISTEN_73 || s == ST_LISTEN_RRR) begin
                  st = ST_IDLE;
                end else if (!in_cq_phase(s)) begin
                  r.disarm_and_clear = 1'b1;
                  st = ST_IDLE;
                end
              end
              RX_RR73, RX_RRR: begin
                if (s == ST_LISTEN_73 || s == ST_LISTEN_RRR) begin
                  r.load_remote_info = 1'b1;
                  r.prepare_valid = 1'b1;
                  r.prepared_kind = TX_73;
                  st = ST_M73_PENDING;
                end else if (!in_cq_phase(s)) begin
                  r.disarm_and_clear = 1'b1;
                  st = ST_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
        ACT_CQ: begin
          if (s == ST_IDLE || s == ST_LOC_PENDING) begin
            r.prepare_valid = 1'b1;
            r.prepared_kind = TX_CQ;
            st = ST_CQ_PENDING;
          end else if (in_cq_phase(s)) begin
            r.disarm_and_clear = 1'b1;
            st = ST_IDLE;
          end
        end
        default: begin
          if (e.click_valid && (s == ST_IDLE || s == ST_CQ_PENDING)) begin
            r.qso_start = 1'b1;
            remote_odd = e.click_slot_odd;
            r.save_locator = 1'b1;
            r.load_remote_info = 1'b1;
            r.prepare_valid = 1'b1;
            r.prepared_kind = TX_LOC;
            st = ST_LOC_PENDING;
          end
        end
      endcase
      r.state_now = st;
      r.qso_slot_odd = remote_odd;
      due_results.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(seq_result_t got);
      seq_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with no transaction outstanding, expected none, actual state %0d",
                 $time, got.state_now);
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("state_now", 32'(want.state_now), 32'(got.state_now));
      check_field("arm_transmit", 32'(want.arm_transmit), 32'(got.arm_transmit));
      check_field("prepare_valid", 32'(want.prepare_valid), 32'(got.prepare_valid));
      check_field("prepared_kind", 32'(want.prepared_kind), 32'(got.prepared_kind));
      check_field("disarm_and_clear", 32'(want.disarm_and_clear),
                  32'(got.disarm_and_clear));
      check_field("qso_start", 32'(want.qso_start), 32'(got.qso_start));
      check_field("qso_slot_odd", 32'(want.qso_slot_odd), 32'(got.qso_slot_odd));
      check_field("save_locator", 32'(want.save_locator), 32'(got.save_locator));
      check_field("save_my_report", 32'(want.save_my_report), 32'(got.save_my_report));
      check_field("load_remote_info", 32'(want.load_remote_info),
                  32'(got.load_remote_info));
      check_field("slot_stamp", want.slot_stamp, got.slot_stamp);
    endfunction
  endclass

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_EVENTS = 370;

  logic clk = 1'b0;
  logic rst_n;
  int   src_idle_pct  = 7;
  int   sink_idle_pct = 68;
  int   hold_left     = 0;
  int   stall_cycles;

  sequencer_scoreboard sb = new();

  ft8cs_in_if  in_ch ();
  ft8cs_out_if out_ch ();

  ft8_contact_sequencer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_event(evt_t e);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= e.action;
    in_ch.msg_kind       <= e.msg_kind;
    in_ch.for_us         <= e.for_us;
    in_ch.text_has_rr73  <= e.text_has_rr73;
    in_ch.click_valid    <= e.click_valid;
    in_ch.click_slot_odd <= e.click_slot_odd;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(e);
  endtask

  task automatic drive(action_t a, rx_kind_t k, bit fu, bit rr, bit cv, bit odd);
    evt_t e;
    e.action         = a;
    e.msg_kind       = k;
    e.for_us         = fu;
    e.text_has_rr73  = rr;
    e.click_valid    = cv;
    e.click_slot_odd = odd;
    send_event(e);
  endtask

  // mostly the message the current state is waiting for, with some noise
  function automatic evt_t pick_event();
    evt_t e;
    int   roll;
    e.msg_kind       = 3'($urandom_range(7));
    e.for_us         = 1'($urandom_range(1));
    e.text_has_rr73  = 1'($urandom_range(1));
    e.click_valid    = 1'($urandom_range(1));
    e.click_slot_odd = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (sb.st == ST_IDLE && roll < 55)
      e.action = (roll < 30) ? ACT_CQ : ACT_CLICK;
    else if (roll < 45)
      e.action = ACT_TICK;
    else if (roll < 80)
      e.action = ACT_MSG;
    else if (roll < 90)
      e.action = ACT_CQ;
    else
      e.action = ACT_CLICK;
    if (e.action == ACT_MSG) begin
      e.for_us        = ($urandom_range(99) < 85);
      e.text_has_rr73 = ($urandom_range(99) < 20);
      if ($urandom_range(99) < 70) begin
        case (sb.st)
          ST_CQ_PENDING, ST_LISTEN_LOC:
            e.msg_kind = $urandom_range(1) ? RX_LOC : RX_RSL;
          ST_LISTEN_RRSL, ST_LISTEN_RSL:
            e.msg_kind = $urandom_range(1) ? RX_RSL : RX_RRSL;
          ST_LISTEN_73, ST_LISTEN_RRR:
            e.msg_kind = 3'(RX_73 + $urandom_range(2));
          default: ;
        endcase
      end
    end else if (e.action == ACT_CLICK) begin
      e.click_valid = ($urandom_range(99) < 85);
    end
    return e;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_event(pick_event());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // idle tick with every unused bit high, then an early end from idle
    drive(ACT_TICK,  RX_OTHER, 1, 1, 1, 1);
    drive(ACT_MSG,   RX_73,    1, 0, 0, 0);
    drive(ACT_MSG,   RX_RR73,  0, 0, 0, 0);
    drive(ACT_CLICK, RX_CQ,    0, 0, 0, 1);
    // calling cq: pending, transmit, listen
    drive(ACT_CQ,    RX_CQ,    0, 0, 0, 0);
    drive(ACT_TICK,  RX_CQ,    0, 0, 0, 0);
    drive(ACT_MSG,   RX_RRR,   1, 0, 0, 0);
    drive(ACT_TICK,  RX_CQ,    0, 0, 0, 0);
    drive(ACT_MSG,   RX_CQ,    1, 0, 0, 0);
    drive(ACT_MSG,   RX_LOC,   1, 1, 0, 0);
    drive(ACT_MSG,   RX_LOC,   1, 0, 0, 0);
    drive(ACT_TICK,  RX_CQ,    0, 0, 0, 0);
    drive(ACT_TICK,  RX_CQ,    0, 0, 0, 0);
    drive(ACT_MSG,   RX_RRSL,  1, 0, 0, 0);
    drive(ACT_TICK,  RX_CQ,    0, 0, 0, 0);
    drive(ACT_TICK,  RX_CQ,    0, 0, 0, 0);
    drive(ACT_MSG,   RX_RR73,  1, 0, 0, 0);
    drive(ACT_TICK,  RX_CQ,    0, 0, 0, 0);
    drive(ACT_TICK,  RX_CQ,    0, 0, 0, 0);
    // answering a clicked station, with cq pressed in between
    drive(ACT_CLICK, RX_OTHER, 0, 0, 1, 1);
    drive(ACT_CQ,    RX_CQ,    0, 0, 0, 0);
    drive(ACT_CLICK, RX_CQ,    0, 0, 1, 0);
    drive(ACT_TICK,  RX_CQ,    0, 0, 0, 0);
    drive(ACT_TICK,  RX_CQ,    0, 0, 0, 0);
    drive(ACT_MSG,   RX_RSL,   1, 0, 0, 0);
    drive(ACT_MSG,   RX_OTHER, 1, 1, 1, 1);
    drive(ACT_MSG,   RX_73,    1, 0, 0, 0);
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_TICK;
    in_ch.msg_kind       <= RX_CQ;
    in_ch.for_us         <= 1'b0;
    in_ch.text_has_rr73  <= 1'b0;
    in_ch.click_valid    <= 1'b0;
    in_ch.click_slot_odd <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(PHASE_EVENTS);
    drain();
    src_idle_pct  = 68;
    sink_idle_pct = 7;
    run_random(PHASE_EVENTS);
    drain();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    // long receiver hold-off so the core fills and backs up its input
    hold_left = HOLD_CYCLES;
    run_random(PHASE_EVENTS);
    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    seq_result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.state_now        = seq_state_t'(out_ch.state_now);
        got.arm_transmit     = out_ch.arm_transmit;
        got.prepare_valid    = out_ch.prepare_valid;
        got.prepared_kind    = tx_kind_t'(out_ch.prepared_kind);
        got.disarm_and_clear = out_ch.disarm_and_clear;
        got.qso_start        = out_ch.qso_start;
        got.qso_slot_odd     = out_ch.qso_slot_odd;
        got.save_locator     = out_ch.save_locator;
        got.save_my_report   = out_ch.save_my_report;
        got.load_remote_info = out_ch.load_remote_info;
        got.slot_stamp       = out_ch.slot_stamp;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hdl/ft8cs_pkg.sv
hdl/ft8cs_if.sv
hdl/ft8cs_step.sv
hdl/ft8cs_contact_sequencer_core.sv
verif/ft8_contact_sequencer_core_test.sv
